FILE: rtl/tcphs_pkg.sv
// ----------------------------------------------------------------------------
// tcphs_pkg - shared types and constants for the TCP handshake responder
// Connection table entry layout, TCP flag bit positions and action codes.
// ----------------------------------------------------------------------------
package tcphs_pkg;

	// TCP flag bit positions within the 6-bit flag field
	localparam int FL_FIN = 0;
	localparam int FL_SYN = 1;
	localparam int FL_RST = 2;
	localparam int FL_PSH = 3;
	localparam int FL_ACK = 4;
	localparam int FL_URG = 5;

	localparam int FLAGS_W = 6;

	typedef enum logic [1:0] {
		ACT_PASS = 2'd0,
		ACT_DROP = 2'd1,
		ACT_TX   = 2'd2
	} action_t;

	// one connection table slot
	typedef struct packed {
		logic        valid;
		logic [63:0] addresses;    // src_ip high, dst_ip low
		logic [31:0] ports;        // sport high, dport low
		logic [31:0] client_next;  // client ISN + 1
		logic [31:0] local_isn;
		logic        established;
	} entry_t;

endpackage

FILE: rtl/tcp_handshake_echo_responder_top.sv
// ----------------------------------------------------------------------------
// tcp_handshake_echo_responder_top - TCP handshake and echo responder
// Looks up each parsed segment header in a hashed connection table and
// decides on pass, drop or a reply (SYN-ACK, FIN-ACK, echo ACK).
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Beat contents
//  -------  ---  ------------------------------------------------------------
//  s_*      in   one segment header: tuple, seq, ack, flags, length, ISN
//  m_*      out  one decision: action in tuser, reply seq/ack/flags in tdata
//
//  Each header steps through accept, quotient multiply, slot remainder plus
//  table read, then decide and write back. The reciprocal divide and the
//  registered table read set these steps; only one header is in flight.
//  After reset the table is swept clear, with s_tready low. A finished beat
//  waits in the output register while the next header is taken; only the
//  write-back step stalls on a full output register.
//
module tcp_handshake_echo_responder_top
	import tcphs_pkg::*;
#(
	parameter int TABLE_ENTRIES = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] src_ip, [63:32] dst_ip, [79:64] sport, [95:80] dport,
	// [127:96] seq_in, [159:128] ack_in, [165:160] flags_in,
	// [181:166] seg_len, [213:182] random_isn, [215:214] zero
	input  logic [215:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] reply_seq, [63:32] reply_ack, [69:64] reply_flags,
	// [70] force_window_ttl, [71] zero
	output logic [71:0]  m_tdata,
	// [1:0] action
	output logic [1:0]   m_tuser
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	// reciprocal of the table size, scaled by 2^32, rounded up; exact for
	// every 16-bit fold value, so no correction step follows
	localparam logic [32:0] RECIP =
		33'(((64'd1 << 32) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES));

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_MOD,
		ST_EXEC
	} state_t;

	state_t state_q;

	// captured header
	logic [31:0] src_ip_q, dst_ip_q, seq_q, ack_q, isn_q;
	logic [15:0] src_port_q, dst_port_q, plen_q;
	logic [FLAGS_W-1:0] flags_q;
	logic [15:0] fold_q;
	logic [15:0] quot_q;
	logic [IDX_W-1:0] clr_addr_q;

	// output register
	logic        m_tvalid_q;
	action_t     act_q;
	logic [31:0] rseq_q, rack_q;
	logic [FLAGS_W-1:0] rflags_q;
	logic        force_q;

	// fold of the incoming tuple
	logic [31:0] tuple_x;
	logic [15:0] fold_d;

	assign tuple_x = s_tdata[31:0] ^ s_tdata[63:32] ^ {s_tdata[79:64], s_tdata[95:80]};
	assign fold_d  = tuple_x[31:16] ^ tuple_x[15:0];

	// slot = fold mod TABLE_ENTRIES via reciprocal multiply
	logic [48:0] prod_div;
	logic [32:0] prod_qn;
	logic [32:0] rem_full;
	logic [IDX_W-1:0] slot;

	assign prod_div = 49'(fold_q) * 49'(RECIP);
	assign prod_qn  = 33'(quot_q) * 33'(TABLE_ENTRIES);
	assign rem_full = 33'(fold_q) - prod_qn;
	assign slot     = rem_full[IDX_W-1:0];

	// table
	logic             ram_wr_en, ram_rd_en;
	logic [IDX_W-1:0] ram_wr_addr;
	entry_t           ram_wr_data, ram_rd_data;
	logic [IDX_W-1:0] slot_q;

	tcphs_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (slot),
		.rd_data (ram_rd_data)
	);

	assign ram_rd_en = (state_q == ST_MOD);

	// decision on the entry read back
	logic        out_free, fire, found;
	action_t     act_d;
	logic [31:0] rseq_d, rack_d;
	logic [FLAGS_W-1:0] rflags_d;
	logic        force_d;
	logic        upd_en;
	entry_t      upd_entry;

	assign out_free = !m_tvalid_q || m_tready;
	assign fire     = (state_q == ST_EXEC) && out_free;
	assign found    = ram_rd_data.valid
		&& (ram_rd_data.addresses == {src_ip_q, dst_ip_q})
		&& (ram_rd_data.ports == {src_port_q, dst_port_q});

	always_comb begin
		act_d     = ACT_DROP;
		rseq_d    = '0;
		rack_d    = '0;
		rflags_d  = '0;
		force_d   = 1'b0;
		upd_en    = 1'b0;
		upd_entry = ram_rd_data;
		if (flags_q[FL_SYN]) begin
			if (!found) begin
				// new or colliding tuple: claim the slot as pending
				upd_en                = 1'b1;
				upd_entry.valid       = 1'b1;
				upd_entry.addresses   = {src_ip_q, dst_ip_q};
				upd_entry.ports       = {src_port_q, dst_port_q};
				upd_entry.client_next = seq_q + 32'd1;
				upd_entry.local_isn   = isn_q;
				upd_entry.established = 1'b0;
				act_d                 = ACT_TX;
				rseq_d                = isn_q;
				rack_d                = seq_q + 32'd1;
				rflags_d[FL_SYN]      = 1'b1;
				rflags_d[FL_ACK]      = 1'b1;
				force_d               = 1'b1;
			end else if (!ram_rd_data.established) begin
				// retransmitted SYN: repeat the stored SYN-ACK
				act_d            = ACT_TX;
				rseq_d           = ram_rd_data.local_isn;
				rack_d           = ram_rd_data.client_next;
				rflags_d[FL_SYN] = 1'b1;
				rflags_d[FL_ACK] = 1'b1;
				force_d          = 1'b1;
			end
		end else if (flags_q[FL_FIN]) begin
			if (found) begin
				upd_en           = 1'b1;
				upd_entry.valid  = 1'b0;
				act_d            = ACT_TX;
				rseq_d           = ack_q;
				rack_d           = seq_q + 32'd1 + 32'(plen_q);
				rflags_d[FL_FIN] = 1'b1;
				rflags_d[FL_ACK] = 1'b1;
				rflags_d[FL_URG] = flags_q[FL_URG];
			end
		end else if (flags_q[FL_ACK]) begin
			if (found) begin
				if (!ram_rd_data.established) begin
					upd_en                = 1'b1;
					upd_entry.established = 1'b1;
				end else if (plen_q != 16'd0) begin
					// echo ACK, entry drops back to pending
					upd_en                = 1'b1;
					upd_entry.established = 1'b0;
					act_d                 = ACT_TX;
					rseq_d                = ack_q;
					rack_d                = seq_q + 32'(plen_q);
					rflags_d              = flags_q;
				end
			end
		end else if (flags_q[FL_RST]) begin
			if (found) begin
				upd_en          = 1'b1;
				upd_entry.valid = 1'b0;
			end
		end else begin
			act_d = ACT_PASS;
		end
	end

	// write port: clearing sweep or write-back
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = clr_addr_q;
			ram_wr_data = '0;
		end else begin
			ram_wr_en   = fire && upd_en;
			ram_wr_addr = slot_q;
			ram_wr_data = upd_entry;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	// header capture, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			src_ip_q   <= s_tdata[31:0];
			dst_ip_q   <= s_tdata[63:32];
			src_port_q <= s_tdata[79:64];
			dst_port_q <= s_tdata[95:80];
			seq_q      <= s_tdata[127:96];
			ack_q      <= s_tdata[159:128];
			flags_q    <= s_tdata[165:160];
			plen_q     <= s_tdata[181:166];
			isn_q      <= s_tdata[213:182];
			fold_q     <= fold_d;
		end
		if (state_q == ST_DIV) begin
			quot_q <= prod_div[47:32];
		end
		if (state_q == ST_MOD) begin
			slot_q <= slot;
		end
	end

	// control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			m_tvalid_q <= 1'b0;
			act_q      <= ACT_DROP;
			rseq_q     <= '0;
			rack_q     <= '0;
			rflags_q   <= '0;
			force_q    <= 1'b0;
		end else begin
			// load on a finished decision, clear once taken
			if (fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + IDX_W'(1);
					if (clr_addr_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (out_free) begin
						act_q      <= act_d;
						rseq_q     <= rseq_d;
						rack_q     <= rack_d;
						rflags_q   <= rflags_d;
						force_q    <= force_d;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, force_q, rflags_q, rack_q, rseq_q};
	assign m_tuser  = act_q;

endmodule

FILE: rtl/tcphs_ram.sv
// ----------------------------------------------------------------------------
// tcphs_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tcphs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for tcp_handshake_echo_responder_top
// Drives segment headers on the s_* stream and checks every decision beat on
// m_* against a connection-table model kept inside the bench. A short table
// of directed headers runs first. Random traffic on a small pool of colliding
// connections follows, under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench
	import tcphs_pkg::*;
();

	localparam int CONN_SLOTS   = 1024;     // matches the DUT default
	localparam int RAND_HEADERS = 1424;     // plus the directed rows, ~1450 total
	localparam int POOL_SIZE    = 16;
	localparam int CYCLE_LIMIT  = 400000;   // sweep + worst pacing, many times over
	localparam int DRAIN_CYCLES = 12;       // pipeline drain, with margin
	localparam int HOLD_CYCLES  = 400;      // long receiver hold-off

	// flag masks built from the package bit positions
	localparam logic [5:0] F_FIN = 6'(1 << FL_FIN);
	localparam logic [5:0] F_SYN = 6'(1 << FL_SYN);
	localparam logic [5:0] F_RST = 6'(1 << FL_RST);
	localparam logic [5:0] F_PSH = 6'(1 << FL_PSH);
	localparam logic [5:0] F_ACK = 6'(1 << FL_ACK);
	localparam logic [5:0] F_URG = 6'(1 << FL_URG);

	typedef struct packed {
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sport;
		logic [15:0] dport;
	} tuple_t;

	typedef struct packed {
		tuple_t      tup;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [5:0]  flags;
		logic [15:0] plen;
		logic [31:0] isn;
	} segment_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [5:0]  flags;
		logic        win_ttl;
	} decision_t;

	typedef struct {
		segment_t  seg;
		bit        typed;
		decision_t want;
	} dir_row_t;

	// receiver stall patterns
	typedef enum int {
		SINK_OPEN,
		SINK_HALF,
		SINK_SPARSE,
		SINK_MOSTLY,
		SINK_HOLD
	} sink_mode_t;

	// DUT ports; the bench-driven inputs are known from time zero
	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [215:0] s_tdata  = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [71:0]  m_tdata;
	logic [1:0]   m_tuser;

	// bench copy of the connection table
	bit          conn_valid [CONN_SLOTS];
	logic [63:0] conn_addr  [CONN_SLOTS];
	logic [31:0] conn_ports [CONN_SLOTS];
	logic [31:0] conn_next  [CONN_SLOTS];
	logic [31:0] conn_isn   [CONN_SLOTS];
	bit          conn_est   [CONN_SLOTS];

	decision_t decision_q[$];      // expected decisions, oldest first
	dir_row_t  dir_rows[$];
	tuple_t    pool[POOL_SIZE];
	int        mismatches     = 0;
	int        accepted_beats = 0;
	int        result_beats   = 0;
	int        burst_left     = 0;

	tcp_handshake_echo_responder_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Model of the responder. Updates the bench table and returns the decision
	// for one header. Priority is SYN, FIN, ACK, RST; nothing set means pass.
	// ------------------------------------------------------------------------
	function automatic decision_t respond_to_segment(input segment_t s);
		decision_t   d;
		logic [63:0] addr;
		logic [31:0] ports;
		logic [31:0] mix;
		logic [15:0] folded;
		int          slot;
		bit          hit;
		addr   = {s.tup.sip, s.tup.dip};
		ports  = {s.tup.sport, s.tup.dport};
		mix    = s.tup.sip ^ s.tup.dip ^ ports;
		folded = mix[31:16] ^ mix[15:0];
		slot   = int'(folded) % CONN_SLOTS;
		hit    = conn_valid[slot] && conn_addr[slot] == addr && conn_ports[slot] == ports;
		d.action  = ACT_DROP;
		d.seq     = '0;
		d.ack     = '0;
		d.flags   = '0;
		d.win_ttl = 1'b0;
		if (s.flags & F_SYN) begin
			if (!hit) begin
				// new connection, or a collision: the slot is taken over
				conn_valid[slot] = 1'b1;
				conn_addr[slot]  = addr;
				conn_ports[slot] = ports;
				conn_next[slot]  = s.seq + 32'd1;
				conn_isn[slot]   = s.isn;
				conn_est[slot]   = 1'b0;
				d.action  = ACT_TX;
				d.seq     = s.isn;
				d.ack     = s.seq + 32'd1;
				d.flags   = F_SYN | F_ACK;
				d.win_ttl = 1'b1;
			end else if (!conn_est[slot]) begin
				// retransmitted SYN while pending: same SYN-ACK as before
				d.action  = ACT_TX;
				d.seq     = conn_isn[slot];
				d.ack     = conn_next[slot];
				d.flags   = F_SYN | F_ACK;
				d.win_ttl = 1'b1;
			end
		end else if (s.flags & F_FIN) begin
			if (hit) begin
				conn_valid[slot] = 1'b0;
				d.action = ACT_TX;
				d.seq    = s.ack;
				d.ack    = s.seq + 32'd1 + 32'(s.plen);
				d.flags  = (s.flags & F_URG) | F_FIN | F_ACK;
			end
		end else if (s.flags & F_ACK) begin
			if (hit) begin
				if (!conn_est[slot]) begin
					conn_est[slot] = 1'b1;
				end else if (s.plen != 16'd0) begin
					// echo the data ack, connection drops back to pending
					conn_est[slot] = 1'b0;
					d.action = ACT_TX;
					d.seq    = s.ack;
					d.ack    = s.seq + 32'(s.plen);
					d.flags  = s.flags | F_ACK;
				end
			end
		end else if (s.flags & F_RST) begin
			if (hit) begin
				conn_valid[slot] = 1'b0;
			end
		end else begin
			d.action = ACT_PASS;
		end
		return d;
	endfunction

	function automatic decision_t decision(input action_t a, input logic [31:0] sq,
			input logic [31:0] ak, input logic [5:0] fl, input logic wt);
		decision_t d;
		d.action  = a;
		d.seq     = sq;
		d.ack     = ak;
		d.flags   = fl;
		d.win_ttl = wt;
		return d;
	endfunction

	function automatic segment_t segment(input tuple_t t, input logic [31:0] sq,
			input logic [31:0] ak, input logic [5:0] fl, input logic [15:0] pl,
			input logic [31:0] isn);
		segment_t s;
		s.tup   = t;
		s.seq   = sq;
		s.ack   = ak;
		s.flags = fl;
		s.plen  = pl;
		s.isn   = isn;
		return s;
	endfunction

	function automatic tuple_t tuple(input logic [31:0] sip, input logic [31:0] dip,
			input logic [15:0] sport, input logic [15:0] dport);
		tuple_t t;
		t.sip   = sip;
		t.dip   = dip;
		t.sport = sport;
		t.dport = dport;
		return t;
	endfunction

	// swapping the addresses keeps the folded index: a guaranteed collision
	function automatic tuple_t swapped(input tuple_t t);
		return tuple(t.dip, t.sip, t.sport, t.dport);
	endfunction

	function automatic tuple_t random_tuple();
		return tuple($urandom, $urandom, 16'($urandom), 16'($urandom));
	endfunction

	function automatic logic [15:0] random_length();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			return 16'd0;
		end else if (pick < 7) begin
			return 16'($urandom_range(1, 1460));
		end
		return 16'($urandom);
	endfunction

	// ------------------------------------------------------------------------
	// Random header: mostly traffic on the pool so connections get through
	// SYN, ACK, data and FIN; the rest is noise on random tuples and flags.
	// ------------------------------------------------------------------------
	function automatic segment_t random_segment();
		segment_t    s;
		logic [5:0]  extra;
		int          pick;
		s     = segment(pool[$urandom_range(0, POOL_SIZE - 1)], $urandom, $urandom,
			6'd0, random_length(), $urandom);
		extra = 6'($urandom);
		pick  = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 12) begin
			s.tup   = random_tuple();
			s.flags = extra;
		end else if (pick < 20) begin
			s.flags = F_SYN | extra;
		end else if (pick < 38) begin
			s.flags = F_ACK | (extra & (F_PSH | F_URG | F_RST));
			s.plen  = 16'd0;
		end else if (pick < 64) begin
			s.flags = F_ACK | (extra & (F_PSH | F_URG | F_RST));
			if (s.plen == 16'd0) begin
				s.plen = 16'($urandom_range(1, 65535));
			end
		end else if (pick < 75) begin
			s.flags = F_FIN | (extra & (F_ACK | F_PSH | F_URG | F_RST));
		end else if (pick < 83) begin
			s.flags = F_RST | (extra & (F_PSH | F_URG));
		end else if (pick < 88) begin
			s.flags = extra & (F_PSH | F_URG);
		end else begin
			s.flags = extra;
		end
		return s;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at beat %0d, %s: got %h, expected %h",
			result_beats, field, got, want);
		mismatches++;
	endtask

	task automatic add_checked(input segment_t s);
		dir_row_t r;
		r.seg   = s;
		r.typed = 1'b0;
		r.want  = decision(ACT_DROP, '0, '0, '0, 1'b0);
		dir_rows.push_back(r);
	endtask

	task automatic add_typed(input segment_t s, input decision_t w);
		dir_row_t r;
		r.seg   = s;
		r.typed = 1'b1;
		r.want  = w;
		dir_rows.push_back(r);
	endtask

	// ------------------------------------------------------------------------
	// Sender side. Called at a falling edge; returns at a falling edge. Bursts
	// of random length, separated by random gaps, some runs with no gap.
	// The model runs at the accepting edge, so its table stays in step.
	// ------------------------------------------------------------------------
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic offer(input segment_t s, input bit typed, input decision_t w);
		decision_t d;
		pace_sender();
		// fields packed from src_ip in the low bits up to random_isn
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, s.isn, s.plen, s.flags, s.ack, s.seq,
			s.tup.dport, s.tup.sport, s.tup.dip, s.tup.sip};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		d = respond_to_segment(s);
		decision_q.push_back(typed ? w : d);
		accepted_beats++;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Result checker: every m_* beat against the oldest expectation.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : beat_check
		decision_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (decision_q.size() == 0) begin
				report_mismatch("beat with nothing expected", m_tdata[31:0], '0);
			end else begin
				want = decision_q.pop_front();
				if (m_tuser != want.action)
					report_mismatch("action", 32'(m_tuser), 32'(want.action));
				if (m_tdata[31:0] != want.seq)
					report_mismatch("reply_seq", m_tdata[31:0], want.seq);
				if (m_tdata[63:32] != want.ack)
					report_mismatch("reply_ack", m_tdata[63:32], want.ack);
				if (m_tdata[69:64] != want.flags)
					report_mismatch("reply_flags", 32'(m_tdata[69:64]), 32'(want.flags));
				if (m_tdata[70] != want.win_ttl)
					report_mismatch("force_window_ttl", 32'(m_tdata[70]), 32'(want.win_ttl));
				if (m_tdata[71] != 1'b0)
					report_mismatch("tdata pad bit", 32'(m_tdata[71]), '0);
			end
			result_beats++;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver side: stall patterns of random length. Once traffic is flowing
	// it holds off for a long stretch so the output fills and s_tready drops.
	// ------------------------------------------------------------------------
	initial begin : sink_pacing
		sink_mode_t mode;
		int         span;
		bit         held_off;
		held_off = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = sink_mode_t'($urandom_range(SINK_OPEN, SINK_MOSTLY));
			span = $urandom_range(4, 60);
			if (!held_off && accepted_beats >= 40) begin
				held_off = 1'b1;
				mode     = SINK_HOLD;
				span     = HOLD_CYCLES;
			end
			repeat (span) begin
				@(negedge clk);
				case (mode)
					SINK_OPEN:   m_tready <= 1'b1;
					SINK_HALF:   m_tready <= 1'($urandom_range(0, 1));
					SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					SINK_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
					default:     m_tready <= 1'b0;
				endcase
			end
		end
	end

	// run limit, counted in clock cycles
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL tcp_handshake_echo_responder_top");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence: reset, directed rows, random traffic, drain, verdict.
	// ------------------------------------------------------------------------
	initial begin : stimulus
		tuple_t t_a;
		tuple_t t_b;
		tuple_t t_ones;
		tuple_t t_zero;
		tuple_t t_clash;
		for (int i = 0; i < CONN_SLOTS; i++) begin
			conn_valid[i] = 1'b0;
			conn_est[i]   = 1'b0;
		end

		t_a     = tuple(32'hC0A8_0001, 32'h0A00_0002, 16'd40000, 16'd7);
		t_b     = swapped(t_a);              // same slot as t_a, other tuple
		t_ones  = tuple('1, '1, '1, '1);
		t_zero  = tuple('0, '0, '0, '0);
		t_clash = tuple(32'h5A5A_A5A5, 32'h5A5A_A5A5, '0, '0);  // folds to slot 0

		// no flags of interest and misses on an empty table
		add_typed(segment(t_a, 32'd100, 32'd200, 6'd0, 16'd0, 32'd1),
			decision(ACT_PASS, '0, '0, '0, 1'b0));
		add_typed(segment(t_a, 32'd100, 32'd200, F_ACK, 16'd10, 32'd1),
			decision(ACT_DROP, '0, '0, '0, 1'b0));
		add_typed(segment(t_a, 32'd100, 32'd200, F_FIN, 16'd0, 32'd1),
			decision(ACT_DROP, '0, '0, '0, 1'b0));
		add_typed(segment(t_a, 32'd100, 32'd200, F_RST, 16'd0, 32'd1),
			decision(ACT_DROP, '0, '0, '0, 1'b0));
		add_typed(segment(t_a, 32'd100, 32'd200, F_PSH | F_URG, 16'd5, 32'd1),
			decision(ACT_PASS, '0, '0, '0, 1'b0));
		// new SYN at the top of the sequence space: ack wraps to zero
		add_typed(segment(t_a, '1, '0, F_SYN, 16'd0, '1),
			decision(ACT_TX, '1, '0, F_SYN | F_ACK, 1'b1));
		add_checked(segment(t_a, 32'd5, 32'd6, F_SYN, 16'd0, '0));    // resend SYN-ACK
		add_checked(segment(t_b, 32'd0, 32'd0, F_ACK, 16'd0, '0));    // collision, miss
		add_checked(segment(t_a, '0, '0, F_ACK, 16'd0, '0));          // establish
		add_checked(segment(t_a, '0, '0, F_ACK, 16'd0, '0));          // no data, drop
		add_checked(segment(t_a, '0, '0, F_SYN, 16'd0, '0));          // SYN on established
		add_checked(segment(t_a, '1, '0, F_ACK | F_PSH, '1, '0));     // echo, wraps
		add_checked(segment(t_a, '0, '0, F_ACK, 16'd0, '0));          // establish again
		add_checked(segment(t_a, '1, '1, F_FIN | F_ACK | F_URG, '1, '0));  // FIN-ACK
		add_checked(segment(t_a, '0, '0, F_RST, 16'd0, '0));          // already closed
		add_checked(segment(t_ones, '1, '1, '1, '1, '1));             // all flags, SYN wins
		add_checked(segment(t_ones, '1, '1, '1, '1, '0));             // pending resend
		add_checked(segment(t_ones, '1, '1, F_FIN | F_RST | F_ACK, '1, '1));
		add_typed(segment(t_zero, '0, '0, F_SYN, '0, '0),
			decision(ACT_TX, '0, 32'd1, F_SYN | F_ACK, 1'b1));
		add_checked(segment(t_clash, 32'd77, '0, F_SYN, '0, 32'hDEAD_BEEF));  // takes slot
		add_checked(segment(t_zero, '0, '0, F_ACK, '0, '0));          // evicted, miss
		add_checked(segment(t_clash, '0, '0, F_ACK, '0, '0));         // establish
		add_checked(segment(t_clash, '0, '0, F_ACK | F_RST, '0, '0)); // ACK before RST
		add_checked(segment(t_clash, '0, '0, F_RST, '0, '0));         // close
		add_checked(segment(t_clash, '0, '0, F_ACK, 16'd3, '0));      // miss after RST

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i].seg, dir_rows[i].typed, dir_rows[i].want);

		// pairs of colliding connections so slot takeover happens often
		for (int i = 0; i < POOL_SIZE; i += 2) begin
			pool[i]     = random_tuple();
			pool[i + 1] = swapped(pool[i]);
		end
		repeat (RAND_HEADERS)
			offer(random_segment(), 1'b0, decision(ACT_DROP, '0, '0, '0, 1'b0));
		s_tvalid <= 1'b0;

		while (decision_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS tcp_handshake_echo_responder_top");
		end else begin
			$display("FAIL tcp_handshake_echo_responder_top");
		end
		$finish;
	end

endmodule

FILE: tcp_handshake_echo_responder_top.f
rtl/tcphs_pkg.sv
rtl/tcphs_ram.sv
rtl/tcp_handshake_echo_responder_top.sv
bench/testbench.sv
